>>> rtl/core/ecb_pkg.sv
// Package for the edge coverage bitmap: field widths, defaults and shared types.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package ecb_pkg;

    localparam int ADDR_W           = 64;
    localparam int CNT_W            = 8;
    localparam int BUCKET_COUNT_DEF = 16384;
    localparam int RES_DEPTH_DEF    = 4;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

    typedef struct packed {
        logic push;
        logic push_data;
        logic pop;
    } t_res_ctl;

endpackage

`default_nettype wire

>>> rtl/core/edge_coverage_bitmap.sv
// Edge coverage bitmap: address stream in, one interesting flag per trace out.
// Depends on ecb_pkg and ecb_result_fifo.
//
// Input channel (i_in_valid / o_in_ready) carries one trace address per
// transaction with first and last marks. Each non-first address is paired
// with the previous one; their XOR, reduced to the low bits, picks an 8-bit
// hit counter in a single-port-write, registered-read RAM of BUCKET_COUNT
// entries (a power of two). The counter is read on the accept cycle and
// incremented and written back in the next cycle; a write to the same entry
// in the previous cycle is forwarded into the update.
// Output channel (o_out_valid / i_out_ready) carries one transaction per
// trace, on its last address: 1 if any counter of the trace read zero.
// A result passes the update stage, then the result queue, to o_out_valid.
// Throughput is one address per cycle unless stalled, set by the one RAM
// read and one write per address. A small result queue absorbs output
// stalls; input ready drops only once that queue plus the result in
// flight would fill. After reset the RAM is swept to zero, one entry a
// cycle, all BUCKET_COUNT entries; o_in_ready stays low during the sweep.
`default_nettype none

module edge_coverage_bitmap #(
    parameter int BUCKET_COUNT = ecb_pkg::BUCKET_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [ecb_pkg::ADDR_W-1:0] i_trace_address,
    input  wire logic                       i_first_of_trace,
    input  wire logic                       i_last_of_trace,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_trace_was_interesting
);

    localparam int IDX_W     = $clog2(BUCKET_COUNT);
    localparam int CNT_W     = ecb_pkg::CNT_W;
    localparam int RES_DEPTH = ecb_pkg::RES_DEPTH_DEF;
    localparam int RC_W      = $clog2(RES_DEPTH+1);

    logic [CNT_W-1:0] r_mem [BUCKET_COUNT];

    ecb_pkg::t_state            r_state, n_state;
    logic [IDX_W-1:0]           r_clr_idx;
    logic [ecb_pkg::ADDR_W-1:0] r_prev;
    logic                       r_flag, n_flag;

    logic                       r_s1_valid;
    logic                       r_s1_first;
    logic                       r_s1_last;
    logic [IDX_W-1:0]           r_s1_idx;
    logic [CNT_W-1:0]           r_rd_data;

    logic                       r_lw_valid;
    logic [IDX_W-1:0]           r_lw_idx;
    logic [CNT_W-1:0]           r_lw_data;

    logic                       w_accept;
    logic [ecb_pkg::ADDR_W-1:0] w_edge;
    logic [IDX_W-1:0]           w_idx;
    logic [CNT_W-1:0]           w_before;
    logic [CNT_W-1:0]           w_after;
    logic                       w_upd;
    logic                       w_flag_now;
    logic                       w_wr_en;
    logic [IDX_W-1:0]           w_wr_idx;
    logic [CNT_W-1:0]           w_wr_data;
    logic [RC_W-1:0]            w_res_count;
    logic [RC_W:0]              w_res_need;
    ecb_pkg::t_res_ctl          w_res_ctl;

    // Input side
    assign w_res_need = {1'b0, w_res_count} + (RC_W+1)'(r_s1_valid && r_s1_last);
    assign o_in_ready = (r_state == ecb_pkg::ST_RUN) && (w_res_need < (RC_W+1)'(RES_DEPTH));
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_edge     = r_prev ^ i_trace_address;
    assign w_idx      = w_edge[IDX_W-1:0];

    // Update stage: forward the write of the previous cycle
    assign w_before   = (r_lw_valid && (r_lw_idx == r_s1_idx)) ? r_lw_data : r_rd_data;
    assign w_after    = w_before + 1'b1;
    assign w_upd      = r_s1_valid && !r_s1_first;
    assign w_flag_now = (r_s1_first ? 1'b0 : r_flag) | (w_upd && (w_before == '0));
    assign n_flag     = (r_s1_valid && r_s1_last) ? 1'b0
                      : (r_s1_valid ? w_flag_now : r_flag);

    // RAM write port: clearing sweep or counter update
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_idx  = r_s1_idx;
        w_wr_data = w_after;
        unique case (r_state)
            ecb_pkg::ST_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_idx  = r_clr_idx;
                w_wr_data = '0;
            end
            ecb_pkg::ST_RUN: begin
                w_wr_en = w_upd;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ecb_pkg::ST_CLEAR: begin
                if (r_clr_idx == IDX_W'(BUCKET_COUNT-1)) begin
                    n_state = ecb_pkg::ST_RUN;
                end
            end
            ecb_pkg::ST_RUN: begin
                n_state = ecb_pkg::ST_RUN;
            end
            default: begin
                n_state = ecb_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ecb_pkg::ST_CLEAR;
            r_clr_idx  <= '0;
            r_prev     <= '0;
            r_flag     <= 1'b0;
            r_s1_valid <= 1'b0;
            r_lw_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_flag     <= n_flag;
            r_s1_valid <= w_accept;
            r_lw_valid <= w_wr_en && (r_state == ecb_pkg::ST_RUN);
            if (r_state == ecb_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_accept) begin
                r_prev <= i_trace_address;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lw_idx  <= w_wr_idx;
        r_lw_data <= w_wr_data;
        if (w_accept) begin
            r_s1_first <= i_first_of_trace;
            r_s1_last  <= i_last_of_trace;
            r_s1_idx   <= w_idx;
        end
    end

    // Hit counter RAM
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_idx] <= w_wr_data;
        end
    end

    // Result queue
    assign w_res_ctl.push      = r_s1_valid && r_s1_last;
    assign w_res_ctl.push_data = w_flag_now;
    assign w_res_ctl.pop       = o_out_valid && i_out_ready;

    ecb_result_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_res_ctl),
        .o_valid (o_out_valid),
        .o_data  (o_trace_was_interesting),
        .o_count (w_res_count)
    );

endmodule

`default_nettype wire

>>> rtl/core/ecb_result_fifo.sv
// Small result queue between the counter update stage and the output channel.
// Depends on ecb_pkg for the control struct and the default depth.
`default_nettype none

module ecb_result_fifo #(
    parameter int DEPTH = ecb_pkg::RES_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ecb_pkg::t_res_ctl          i_ctl,
    output logic                            o_valid,
    output logic                            o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [DEPTH-1:0] r_mem;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_ctl.push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_ctl.pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        priority if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_count = r_count - 1'b1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_ctl.push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire
